// ===== sv/gbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_pkg: shared types and constants for greedy box suppression
// Request layouts, the per-cell box record and the cell control codes.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int POS_W   = 12;
  localparam int SIZE_W  = 13;
  localparam int SCORE_W = 16;
  localparam int THR_W   = 16;
  localparam int AREA_W  = 2 * SIZE_W;
  localparam int EDGE_W  = SIZE_W + 1;
  localparam int INTER_W = 2 * SIZE_W;
  localparam int UNION_W = AREA_W + 1;
  localparam int PROD_W  = UNION_W + THR_W;

  localparam int MAX_BOXES_DEF  = 64;
  localparam int COORD_BITS_DEF = 12;

  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_SHIFT  = 2'd2;

  typedef struct packed {
    logic               box_valid;
    logic [POS_W-1:0]   box_left;
    logic [POS_W-1:0]   box_top;
    logic [SIZE_W-1:0]  box_width;
    logic [SIZE_W-1:0]  box_height;
    logic [SCORE_W-1:0] box_score;
    logic               set_end;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]   kept_left;
    logic [POS_W-1:0]   kept_top;
    logic [SIZE_W-1:0]  kept_width;
    logic [SIZE_W-1:0]  kept_height;
    logic [SCORE_W-1:0] kept_score;
    logic               run_last;
    logic               dropped_overflow;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic               supp;
    logic [POS_W-1:0]   left;
    logic [POS_W-1:0]   top;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [SCORE_W-1:0] score;
    logic [AREA_W-1:0]  area;
  } box_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       apply;
  } cell_ctrl_t;

  localparam box_t BOX_EMPTY = '0;

endpackage

// ===== sv/greedy_box_suppression.sv =====
`timescale 1ns / 1ps
// Loading accepts one request per cycle; the chain inserts each box in sorted place.
// The set-closing request starts the sweep: a suppressed box is simply shifted out
// of the head, while a kept box waits in ST_WAIT for the overlap pipeline in every cell.
// A result leaves once the next kept box is found or the sweep ends.
// Synchronous active-low reset empties the chain and sets the threshold to 0.5.
// ----------------------------------------------------------------------------
// greedy_box_suppression: greedy non-maximum suppression by IoU
// Sorts candidate boxes by confidence in a chain of cells, then walks the
// sorted list and emits every box that no higher-ranked kept box overlaps.
// ----------------------------------------------------------------------------
module greedy_box_suppression import gbs_pkg::*; #(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam logic [POS_W-1:0] POS_MASK =
    (COORD_BITS >= POS_W) ? '1 : POS_W'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [SIZE_W-1:0] SIZE_MASK =
    (COORD_BITS + 1 >= SIZE_W) ? '1 : SIZE_W'((64'd1 << (COORD_BITS + 1)) - 64'd1);

  // Sequencer states.
  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [1:0]       wait_r, wait_nxt;
  logic [THR_W-1:0] thr_r;
  box_t             hold_r;
  logic             hold_valid_r, hold_valid_nxt;
  logic             hold_load;
  logic             push, push_last;
  logic             out_valid_r;
  out_t             out_data_r;
  logic             accept, out_free;
  box_t             new_box;
  cell_ctrl_t       ctrl;
  box_t             cell_q [MAX_BOXES];
  logic             ahead_q [MAX_BOXES];
  box_t             head;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_LOAD);
  assign out_free = !out_valid_r || !out_stall;
  assign head     = cell_q[0];

  // The incoming box, masked to the coordinate range, with its area worked
  // out once here so the cells do not compute box areas themselves.
  always_comb begin
    new_box        = BOX_EMPTY;
    new_box.valid  = 1'b1;
    new_box.supp   = 1'b0;
    new_box.left   = in_data.box_left & POS_MASK;
    new_box.top    = in_data.box_top & POS_MASK;
    new_box.width  = in_data.box_width & SIZE_MASK;
    new_box.height = in_data.box_height & SIZE_MASK;
    new_box.score  = in_data.box_score;
    new_box.area   = AREA_W'(new_box.width * new_box.height);
  end

  // The chain. During loading each request lands in its sorted slot while
  // the lower-ranked boxes move one slot down. During the sweep the chain
  // shifts toward slot zero, so the head is always the next box in rank
  // order. The kept box in hold_r is broadcast to every cell, and each cell
  // marks its own box suppressed when the overlap test fires.
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    box_t prev_b, next_b;
    logic prev_bf;
    if (i == 0) begin : g_first
      assign prev_b  = BOX_EMPTY;
      assign prev_bf = 1'b0;
    end else begin : g_mid
      assign prev_b  = cell_q[i-1];
      assign prev_bf = ahead_q[i-1];
    end
    if (i == MAX_BOXES - 1) begin : g_last
      assign next_b = BOX_EMPTY;
    end else begin : g_inner
      assign next_b = cell_q[i+1];
    end
    gbs_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_box     (new_box),
      .prev_box    (prev_b),
      .prev_ahead  (prev_bf),
      .next_box    (next_b),
      .kept        (hold_r),
      .thr         (thr_r),
      .box         (cell_q[i]),
      .ahead       (ahead_q[i])
    );
  end

  // A kept box waits in hold_r until the next kept box shows up or the
  // sweep ends; only then is it known whether it is the last of the set.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    wait_nxt       = wait_r;
    hold_valid_nxt = hold_valid_r;
    hold_load      = 1'b0;
    push           = 1'b0;
    push_last      = 1'b0;
    ctrl.mode      = CELL_HOLD;
    ctrl.apply     = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (in_data.box_valid) begin
            if (count_r < CNT_W'(MAX_BOXES)) begin
              ctrl.mode = CELL_INSERT;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (in_data.set_end) begin
            state_nxt = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (!head.valid) begin
          state_nxt = ST_FLUSH;
        end else if (head.supp) begin
          ctrl.mode = CELL_SHIFT;
        end else if (!hold_valid_r || out_free) begin
          push           = hold_valid_r;
          hold_load      = 1'b1;
          hold_valid_nxt = 1'b1;
          ctrl.mode      = CELL_SHIFT;
          wait_nxt       = 2'd0;
          state_nxt      = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // Let the cell overlap pipeline settle on the new broadcast box.
        if (wait_r == 2'd3) begin
          ctrl.apply = 1'b1;
          state_nxt  = ST_SWEEP;
        end else begin
          wait_nxt = wait_r + 2'd1;
        end
      end
      ST_FLUSH: begin
        if (!hold_valid_r || out_free) begin
          push           = hold_valid_r;
          push_last      = 1'b1;
          hold_valid_nxt = 1'b0;
          count_nxt      = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      wait_r       <= 2'd0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      thr_r        <= THR_W'(32768);
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      wait_r       <= wait_nxt;
      hold_valid_r <= hold_valid_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (psel && penable && pwrite && !paddr[2]) begin
        thr_r <= pwdata[THR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      hold_r <= head;
    end
    if (push) begin
      out_data_r.kept_left        <= hold_r.left;
      out_data_r.kept_top         <= hold_r.top;
      out_data_r.kept_width       <= hold_r.width;
      out_data_r.kept_height      <= hold_r.height;
      out_data_r.kept_score       <= hold_r.score;
      out_data_r.run_last         <= push_last;
      out_data_r.dropped_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? 32'd0 : {16'd0, thr_r};

endmodule

// ===== sv/gbs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_cell: one slot of the sorted box chain
// Holds one box, takes part in sorted insertion and shifting, and tests its
// box against the broadcast kept box in a short overlap pipeline.
// ----------------------------------------------------------------------------
module gbs_cell import gbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl,
  input  box_t             new_box,
  input  box_t             prev_box,
  input  logic             prev_ahead,
  input  box_t             next_box,
  input  box_t             kept,
  input  logic [THR_W-1:0] thr,
  output box_t             box,
  output logic             ahead
);

  box_t                box_r, box_nxt;
  logic [EDGE_W-1:0]   kr, cr, kb, cb, x2, y2;
  logic [POS_W-1:0]    x1, y1;
  logic [SIZE_W-1:0]   dx_nxt, dy_nxt, dx_r, dy_r;
  logic [INTER_W-1:0]  inter_r, inter2_r;
  logic [UNION_W-1:0]  uni;
  logic [PROD_W-1:0]   prod_r;
  logic                hit;

  // The new box goes ahead of every empty slot and of lower scores; equal
  // scores stay ahead of it, which keeps arrival order on ties.
  assign ahead = !box_r.valid || (box_r.score < new_box.score);
  assign box   = box_r;

  always_comb begin
    kr = EDGE_W'(kept.left) + EDGE_W'(kept.width);
    cr = EDGE_W'(box_r.left) + EDGE_W'(box_r.width);
    kb = EDGE_W'(kept.top) + EDGE_W'(kept.height);
    cb = EDGE_W'(box_r.top) + EDGE_W'(box_r.height);
    x1 = (kept.left > box_r.left) ? kept.left : box_r.left;
    y1 = (kept.top > box_r.top) ? kept.top : box_r.top;
    x2 = (kr < cr) ? kr : cr;
    y2 = (kb < cb) ? kb : cb;
    dx_nxt = (x2 > EDGE_W'(x1)) ? SIZE_W'(x2 - EDGE_W'(x1)) : '0;
    dy_nxt = (y2 > EDGE_W'(y1)) ? SIZE_W'(y2 - EDGE_W'(y1)) : '0;
    uni = UNION_W'(kept.area) + UNION_W'(box_r.area) - UNION_W'(inter_r);
  end

  assign hit = PROD_W'({inter2_r, 16'b0}) > prod_r;

  always_comb begin
    box_nxt = box_r;
    unique case (ctrl.mode)
      CELL_INSERT: begin
        if (ahead && !prev_ahead) begin
          box_nxt = new_box;
        end else if (ahead) begin
          box_nxt = prev_box;
        end
      end
      CELL_SHIFT: begin
        box_nxt = next_box;
      end
      CELL_HOLD: begin
        box_nxt = box_r;
      end
      default: begin
        box_nxt = box_r;
      end
    endcase
    if (ctrl.apply && box_r.valid && hit) begin
      box_nxt.supp = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r.valid <= 1'b0;
      box_r.supp  <= 1'b0;
    end else begin
      box_r <= box_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    inter_r  <= INTER_W'(dx_r * dy_r);
    inter2_r <= inter_r;
    prod_r   <= PROD_W'(thr) * PROD_W'(uni);
  end

endmodule

// ===== sv/gbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_checker: port-level checks for greedy box suppression
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module gbs_checker import gbs_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Input stalls only after a set has been closed.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall && in_data.set_end))
    else $error("input stalled without a closed set");

  // A result that is not the last of its set shows only while the sweep runs.
  a_mid_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_last |-> in_stall)
    else $error("intermediate result outside the sweep");

  // The overflow flag is the same on every result of a set.
  a_ovf_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_last |=>
      !out_valid || (out_data.dropped_overflow == $past(out_data.dropped_overflow)))
    else $error("overflow flag changed within a set");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/gbs_kept_box_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbs_kept_box_checker: predicts and checks kept boxes
// Watches the request and result channels and the register writes, runs its
// own greedy suppression over each closed set and compares every kept box.
// ----------------------------------------------------------------------------
module gbs_kept_box_checker import gbs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          kept_pending
);

  localparam int CAP = MAX_BOXES_DEF;

  in_t                set_boxes[$];
  logic               set_overflow;
  logic [THR_W-1:0]   iou_limit;
  out_t               kept_queue[$];

  assign kept_pending = kept_queue.size();

  function automatic logic overlaps_too_much(in_t a, in_t b, logic [THR_W-1:0] limit);
    logic [63:0] x1, y1, x2, y2, inter, uni;
    inter = 0;
    if (a.box_width != 0 && a.box_height != 0 && b.box_width != 0 && b.box_height != 0) begin
      x1 = (a.box_left > b.box_left) ? a.box_left : b.box_left;
      y1 = (a.box_top > b.box_top) ? a.box_top : b.box_top;
      x2 = ((64'(a.box_left) + a.box_width) < (64'(b.box_left) + b.box_width)) ?
           64'(a.box_left) + a.box_width : 64'(b.box_left) + b.box_width;
      y2 = ((64'(a.box_top) + a.box_height) < (64'(b.box_top) + b.box_height)) ?
           64'(a.box_top) + a.box_height : 64'(b.box_top) + b.box_height;
      if (x2 > x1 && y2 > y1) inter = (x2 - x1) * (y2 - y1);
    end
    uni = 64'(a.box_width) * a.box_height + 64'(b.box_width) * b.box_height - inter;
    return (inter * 65536) > (64'(limit) * uni);
  endfunction

  task automatic close_set();
    in_t  ranked[$];
    logic gone[$];
    int   j;
    out_t kb;
    int   first;
    // Stable insertion by descending score.
    foreach (set_boxes[i]) begin
      j = ranked.size();
      while (j > 0 && ranked[j-1].box_score < set_boxes[i].box_score) j--;
      ranked.insert(j, set_boxes[i]);
      gone = {gone, 1'b0};
    end
    first = kept_queue.size();
    foreach (ranked[i]) begin
      if (!gone[i]) begin
        kb = '{ranked[i].box_left, ranked[i].box_top, ranked[i].box_width,
               ranked[i].box_height, ranked[i].box_score, 1'b0, set_overflow};
        kept_queue = {kept_queue, kb};
        for (int k = i + 1; k < ranked.size(); k++)
          if (!gone[k] && overlaps_too_much(ranked[i], ranked[k], iou_limit)) gone[k] = 1'b1;
      end
    end
    if (kept_queue.size() > first) kept_queue[$].run_last = 1'b1;
    set_boxes.delete();
    set_overflow = 1'b0;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      set_boxes.delete();
      kept_queue.delete();
      set_overflow = 1'b0;
      iou_limit    <= THR_W'(32768);
      fail_count   <= 0;
    end else begin
      if (psel && penable && pwrite && pready && !paddr[2]) iou_limit <= pwdata[THR_W-1:0];
      if (in_valid && !in_stall) begin
        if (in_data.box_valid) begin
          if (set_boxes.size() < CAP) set_boxes = {set_boxes, in_data};
          else set_overflow = 1'b1;
        end
        if (in_data.set_end) close_set();
      end
      if (out_valid && !out_stall) begin
        if (kept_queue.size() == 0) begin
          $display("%0t: unexpected kept box %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = kept_queue.pop_front();
          if (out_data !== want) begin
            $display("%0t: kept box mismatch expected %p actual %p", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/greedy_box_suppression_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression_tb: stimulus and verdict for box suppression
// Sends directed and random box sets under several idling phases and
// thresholds; a checker beside the block predicts every kept box.
// ----------------------------------------------------------------------------
module greedy_box_suppression_tb;
  import gbs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          kept_pending;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  greedy_box_suppression dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  gbs_kept_box_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .kept_pending
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // A generous watchdog that fails the run once cycle_count passes 900000.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 900000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drives one request and holds it until the block takes it. The sender may
  // idle first, so gaps fall before any phase of the set. Valid stays up
  // after the request is taken until the next one or the drain.
  task automatic send_request(in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic in_t make_box(logic [11:0] l, logic [11:0] t, logic [12:0] w,
                                   logic [12:0] h, logic [15:0] s, logic last);
    in_t r;
    r = '{1'b1, l, t, w, h, s, last};
    return r;
  endfunction

  // Random geometry: mostly small boxes in a small field so that they overlap,
  // now and then the extremes of each field.
  function automatic in_t random_box(logic last);
    in_t r;
    r.box_valid  = 1'b1;
    r.set_end    = last;
    if ($urandom_range(9) == 0) begin
      r.box_left   = 12'($urandom_range(4095));
      r.box_top    = 12'($urandom_range(4095));
      r.box_width  = 13'($urandom_range(4096));
      r.box_height = 13'($urandom_range(4096));
    end else begin
      r.box_left   = 12'($urandom_range(60));
      r.box_top    = 12'($urandom_range(60));
      r.box_width  = 13'($urandom_range(40));
      r.box_height = 13'($urandom_range(40));
    end
    // Few distinct scores make ties common.
    r.box_score = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) :
                  16'($urandom_range(7) * 9000 + 1);
    return r;
  endfunction

  // Waits for every predicted box, then lets the sweep tail run out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (kept_pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 3'd0;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_set(int boxes);
    for (int i = 0; i < boxes; i++) begin
      // Occasional ignored invalid requests between boxes.
      if ($urandom_range(15) == 0) send_request('0);
      send_request(random_box(i == boxes - 1));
    end
  endtask

  initial begin
    int thr_list[5] = '{0, 65535, 32768, 16384, 49152};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets at the reset threshold: an empty close, a lone box closed by
    // an invalid request, identical boxes with tied scores, zero-area boxes,
    // field extremes and a disjoint pair.
    send_request('{1'b0, 12'd0, 12'd0, 13'd0, 13'd0, 16'd0, 1'b1});
    send_request(make_box(12'd5, 12'd5, 13'd10, 13'd10, 16'd100, 1'b0));
    send_request('{1'b0, 12'hfff, 12'hfff, 13'h1fff, 13'h1fff, 16'hffff, 1'b1});
    send_request(make_box(12'd0, 12'd0, 13'd8, 13'd8, 16'd500, 1'b0));
    send_request(make_box(12'd0, 12'd0, 13'd8, 13'd8, 16'd500, 1'b0));
    send_request(make_box(12'd0, 12'd0, 13'd0, 13'd8, 16'd900, 1'b0));
    send_request(make_box(12'd0, 12'd0, 13'd0, 13'd0, 16'd900, 1'b0));
    send_request(make_box(12'd4095, 12'd4095, 13'd4096, 13'd4096, 16'hffff, 1'b0));
    send_request(make_box(12'd0, 12'd0, 13'd4096, 13'd4096, 16'd0, 1'b0));
    send_request(make_box(12'd100, 12'd100, 13'd4, 13'd4, 16'd1, 1'b1));
    drain();

    // Threshold zero: any overlap suppresses; all-ones: nothing above 65535/65536.
    write_threshold(32'd0);
    send_request(make_box(12'd0, 12'd0, 13'd10, 13'd10, 16'd9, 1'b0));
    send_request(make_box(12'd9, 12'd9, 13'd10, 13'd10, 16'd8, 1'b0));
    send_request(make_box(12'd0, 12'd0, 13'd0, 13'd0, 16'd7, 1'b1));
    drain();
    write_threshold(32'hffffffff);
    send_request(make_box(12'd0, 12'd0, 13'd10, 13'd10, 16'd9, 1'b0));
    send_request(make_box(12'd0, 12'd0, 13'd10, 13'd10, 16'd8, 1'b1));
    drain();

    // Capacity overflow: 66 boxes, the last two dropped.
    write_threshold(32'd32768);
    for (int i = 0; i < 66; i++) send_request(random_box(i == 65));
    drain();

    // Random sets across idling phases and thresholds.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      write_threshold(thr_list[phase]);
      for (int s = 0; s < 8; s++) begin
        int n;
        n = $urandom_range(1, 10);
        random_set(n);
      end
      drain();
    end
    // A last large set at mid idling.
    send_idle_pct = 10;
    recv_stall_pct = 10;
    random_set(64);
    drain();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
